// ===== sv/lrb_pkg.sv =====
// Shared types, codes and lookup functions for the link reconnect backoff supervisor.
`default_nettype none

package lrb_pkg;

  // Widths of the time base and of the delay values.
  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 16;

  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
  localparam logic [15:0]      COUNT_MAX = 16'hFFFF;

  // Event codes carried by the operation field.
  typedef enum logic [3:0] {
    OP_PROVISION = 4'd0,
    OP_DRV_START = 4'd1,
    OP_ASSOC     = 4'd2,
    OP_GOT_IP    = 4'd3,
    OP_LOST_IP   = 4'd4,
    OP_DISCONN   = 4'd5,
    OP_CONN_FAIL = 4'd6,
    OP_TICK      = 4'd7,
    OP_SET_UTC   = 4'd8
  } op_t;

  // Connection phase.
  typedef enum logic [3:0] {
    PH_UNPROV     = 4'd0,
    PH_DISCONN    = 4'd1,
    PH_CONNECTING = 4'd2,
    PH_AUTH_FAIL  = 4'd3,
    PH_AP_UNAVAIL = 4'd4,
    PH_ASSOC_FAIL = 4'd5,
    PH_DHCP       = 4'd6,
    PH_DHCP_FAIL  = 4'd7,
    PH_CONNECTED  = 4'd8,
    PH_FAILED     = 4'd9
  } phase_t;

  // Address lease state.
  typedef enum logic [1:0] {
    LS_UNKNOWN    = 2'd0,
    LS_REQUESTING = 2'd1,
    LS_BOUND      = 2'd2,
    LS_TIMEOUT    = 2'd3
  } lease_t;

  // Retry state.
  typedef enum logic [1:0] {
    RM_DISABLED = 2'd0,
    RM_IDLE     = 2'd1,
    RM_BACKOFF  = 2'd2,
    RM_RETRYING = 2'd3
  } retry_t;

  // Requested action.
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_CONNECT   = 2'd1,
    ACT_RECONNECT = 2'd2
  } action_t;

  // Groups of disconnect reason codes.
  typedef enum logic [1:0] {
    RC_OTHER = 2'd0,
    RC_AUTH  = 2'd1,
    RC_NO_AP = 2'd2,
    RC_ASSOC = 2'd3
  } reason_class_t;

  // Access point visibility, two-bit signed.
  localparam logic signed [1:0] AP_UNKNOWN = -2'sd1;
  localparam logic signed [1:0] AP_NO      = 2'sd0;
  localparam logic signed [1:0] AP_YES     = 2'sd1;

  localparam logic signed [7:0] RSSI_RESET = -8'sd127;

  // Backoff delay for a table index; indexes past the end use the last entry.
  function automatic logic [DelayW-1:0] backoff_delay(input logic [2:0] idx);
    logic [DelayW-1:0] d;
    unique case (idx)
      3'd0:    d = 16'd2000;
      3'd1:    d = 16'd4000;
      3'd2:    d = 16'd8000;
      3'd3:    d = 16'd15000;
      3'd4:    d = 16'd30000;
      default: d = 16'd60000;
    endcase
    return d;
  endfunction

  // Sort a disconnect reason into its group.
  function automatic reason_class_t classify(input logic [15:0] r);
    reason_class_t c;
    unique case (r)
      16'd2, 16'd6, 16'd7, 16'd15, 16'd23, 16'd24, 16'd202, 16'd204:
        c = RC_AUTH;
      16'd200, 16'd201, 16'd210, 16'd211, 16'd212:
        c = RC_NO_AP;
      16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13,
      16'd14, 16'd16, 16'd17, 16'd18, 16'd203:
        c = RC_ASSOC;
      default:
        c = RC_OTHER;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/link_reconnect_backoff_fsm_top.sv =====
// Wireless link supervisor: phase, lease and retry state with exponential backoff.
//
// Each accepted event beat produces exactly one result beat, in the following cycle, holding the
// requested action and a snapshot of the status after the event. The block takes one event
// per clock while the result is not stalled: the whole update is one pass of logic (two 48-bit saturating adds and the
// deadline compares) into the state registers, which also serve as the result register.
// in_ready is high whenever the result register is empty or being drained in the same cycle.
// dhcp_timeout_ms is written through cfg_write/cfg_wdata and resets to 10000.
`default_nettype none

module link_reconnect_backoff_fsm_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration
  input  wire logic               cfg_write,
  input  wire logic [31:0]        cfg_wdata,
  // Event channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         operation,
  input  wire logic [47:0]        now_ms,
  input  wire logic               provisioned,
  input  wire logic signed [7:0]  rssi,
  input  wire logic [7:0]         channel,
  input  wire logic [15:0]        reason,
  input  wire logic [31:0]        utc_seconds,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              action,
  output logic [3:0]              phase,
  output logic [1:0]              lease_state,
  output logic [1:0]              retry_mode,
  output logic                    has_address,
  output logic signed [1:0]       ap_seen,
  output logic signed [7:0]       signal_dbm,
  output logic [7:0]              radio_channel,
  output logic [15:0]             retries,
  output logic [15:0]             backoff_delay_ms,
  output logic [15:0]             last_reason,
  output logic [31:0]             success_utc_s
);

  // Configuration register
  logic [31:0] dhcp_timeout_ms;

  // State registers
  logic                    is_provisioned,  is_provisioned_next;
  lrb_pkg::phase_t         link_phase,      link_phase_next;
  lrb_pkg::lease_t         lease_mode,      lease_mode_next;
  lrb_pkg::retry_t         retry_status,    retry_status_next;
  logic                    address_held,    address_held_next;
  logic signed [1:0]       ap_visibility,   ap_visibility_next;
  logic signed [7:0]       last_rssi,       last_rssi_next;
  logic [7:0]              last_channel,    last_channel_next;
  logic [15:0]             retry_counter,   retry_counter_next;
  logic [15:0]             backoff_value,   backoff_value_next;
  logic [47:0]             retry_deadline,  retry_deadline_next;
  logic [47:0]             lease_deadline,  lease_deadline_next;
  logic [15:0]             disconnect_code, disconnect_code_next;
  logic                    success_set,     success_set_next;
  logic [31:0]             success_wall_s,  success_wall_s_next;
  lrb_pkg::action_t        action_q,        action_next;

  logic                    accept;
  lrb_pkg::op_t            op;

  // Shared backoff arming values
  logic [15:0] arm_counter;
  logic [2:0]  arm_idx;
  logic [15:0] arm_delay;
  logic [48:0] arm_sum;
  logic [47:0] arm_deadline;
  logic [48:0] lease_sum;
  logic [47:0] lease_target;

  // Tick conditions
  logic lease_fire;
  logic retry_fire;
  lrb_pkg::reason_class_t rclass;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign op       = lrb_pkg::op_t'(operation);

  // Arming a backoff: saturating count, table delay, saturating deadline.
  always_comb begin
    arm_counter  = (retry_counter != lrb_pkg::COUNT_MAX) ? retry_counter + 16'd1
                                                          : retry_counter;
    arm_idx      = (retry_counter >= 16'd5) ? 3'd5 : retry_counter[2:0];
    arm_delay    = lrb_pkg::backoff_delay(arm_idx);
    arm_sum      = {1'b0, now_ms} + {33'd0, arm_delay};
    arm_deadline = arm_sum[48] ? lrb_pkg::TIME_MAX : arm_sum[47:0];
    lease_sum    = {1'b0, now_ms} + {17'd0, dhcp_timeout_ms};
    lease_target = lease_sum[48] ? lrb_pkg::TIME_MAX : lease_sum[47:0];
  end

  // Tick decisions. A lease timeout arms a deadline above now unless the add saturated,
  // so the retry then fires in the same tick only when now is the top of the range.
  always_comb begin
    lease_fire = (link_phase == lrb_pkg::PH_DHCP) && (lease_deadline != 48'd0) &&
                 (now_ms >= lease_deadline);
    if (lease_fire) begin
      retry_fire = (now_ms == lrb_pkg::TIME_MAX);
    end else begin
      retry_fire = (retry_status == lrb_pkg::RM_BACKOFF) && (now_ms >= retry_deadline);
    end
    rclass = lrb_pkg::classify(reason);
  end

  // Next state for one event.
  always_comb begin
    is_provisioned_next  = is_provisioned;
    link_phase_next      = link_phase;
    lease_mode_next      = lease_mode;
    retry_status_next    = retry_status;
    address_held_next    = address_held;
    ap_visibility_next   = ap_visibility;
    last_rssi_next       = last_rssi;
    last_channel_next    = last_channel;
    retry_counter_next   = retry_counter;
    backoff_value_next   = backoff_value;
    retry_deadline_next  = retry_deadline;
    lease_deadline_next  = lease_deadline;
    disconnect_code_next = disconnect_code;
    success_set_next     = success_set;
    success_wall_s_next  = success_wall_s;

    unique case (operation)
      lrb_pkg::OP_PROVISION: begin
        is_provisioned_next  = provisioned;
        address_held_next    = 1'b0;
        lease_mode_next      = lrb_pkg::LS_UNKNOWN;
        lease_deadline_next  = '0;
        retry_counter_next   = '0;
        backoff_value_next   = '0;
        disconnect_code_next = '0;
        ap_visibility_next   = lrb_pkg::AP_UNKNOWN;
        last_rssi_next       = lrb_pkg::RSSI_RESET;
        last_channel_next    = '0;
        success_set_next     = 1'b0;
        success_wall_s_next  = '0;
        if (provisioned) begin
          link_phase_next     = lrb_pkg::PH_DISCONN;
          retry_status_next   = lrb_pkg::RM_BACKOFF;
          retry_deadline_next = now_ms;
        end else begin
          link_phase_next     = lrb_pkg::PH_UNPROV;
          retry_status_next   = lrb_pkg::RM_DISABLED;
          retry_deadline_next = '0;
        end
      end
      lrb_pkg::OP_SET_UTC: begin
        if (utc_seconds != 32'd0 && success_set) begin
          success_wall_s_next = utc_seconds;
        end
      end
      lrb_pkg::OP_DRV_START: begin
        if (is_provisioned) begin
          link_phase_next     = lrb_pkg::PH_DISCONN;
          retry_status_next   = lrb_pkg::RM_BACKOFF;
          backoff_value_next  = '0;
          retry_deadline_next = now_ms;
        end
      end
      lrb_pkg::OP_ASSOC: begin
        if (is_provisioned) begin
          link_phase_next     = lrb_pkg::PH_DHCP;
          lease_mode_next     = lrb_pkg::LS_REQUESTING;
          retry_status_next   = lrb_pkg::RM_IDLE;
          backoff_value_next  = '0;
          retry_deadline_next = '0;
          lease_deadline_next = lease_target;
          ap_visibility_next  = lrb_pkg::AP_YES;
        end
      end
      lrb_pkg::OP_GOT_IP: begin
        if (is_provisioned) begin
          link_phase_next     = lrb_pkg::PH_CONNECTED;
          lease_mode_next     = lrb_pkg::LS_BOUND;
          retry_status_next   = lrb_pkg::RM_IDLE;
          address_held_next   = 1'b1;
          ap_visibility_next  = lrb_pkg::AP_YES;
          last_rssi_next      = rssi;
          last_channel_next   = channel;
          retry_counter_next  = '0;
          backoff_value_next  = '0;
          retry_deadline_next = '0;
          lease_deadline_next = '0;
          success_set_next    = (now_ms != 48'd0);
        end
      end
      lrb_pkg::OP_LOST_IP: begin
        if (is_provisioned) begin
          address_held_next   = 1'b0;
          link_phase_next     = lrb_pkg::PH_DHCP_FAIL;
          lease_mode_next     = lrb_pkg::LS_TIMEOUT;
          lease_deadline_next = '0;
          retry_counter_next  = arm_counter;
          backoff_value_next  = arm_delay;
          retry_deadline_next = arm_deadline;
          retry_status_next   = lrb_pkg::RM_BACKOFF;
        end
      end
      lrb_pkg::OP_DISCONN: begin
        if (is_provisioned) begin
          address_held_next    = 1'b0;
          lease_mode_next      = lrb_pkg::LS_UNKNOWN;
          lease_deadline_next  = '0;
          disconnect_code_next = reason;
          unique case (rclass)
            lrb_pkg::RC_AUTH: begin
              link_phase_next    = lrb_pkg::PH_AUTH_FAIL;
              ap_visibility_next = lrb_pkg::AP_YES;
            end
            lrb_pkg::RC_NO_AP: begin
              link_phase_next    = lrb_pkg::PH_AP_UNAVAIL;
              ap_visibility_next = lrb_pkg::AP_NO;
            end
            lrb_pkg::RC_ASSOC: begin
              link_phase_next    = lrb_pkg::PH_ASSOC_FAIL;
              ap_visibility_next = lrb_pkg::AP_YES;
            end
            default: begin
              link_phase_next    = lrb_pkg::PH_DISCONN;
              ap_visibility_next = lrb_pkg::AP_UNKNOWN;
            end
          endcase
          retry_counter_next  = arm_counter;
          backoff_value_next  = arm_delay;
          retry_deadline_next = arm_deadline;
          retry_status_next   = lrb_pkg::RM_BACKOFF;
        end
      end
      lrb_pkg::OP_CONN_FAIL: begin
        if (is_provisioned) begin
          address_held_next   = 1'b0;
          link_phase_next     = lrb_pkg::PH_FAILED;
          lease_mode_next     = lrb_pkg::LS_UNKNOWN;
          ap_visibility_next  = lrb_pkg::AP_UNKNOWN;
          retry_counter_next  = arm_counter;
          backoff_value_next  = arm_delay;
          retry_deadline_next = arm_deadline;
          retry_status_next   = lrb_pkg::RM_BACKOFF;
        end
      end
      lrb_pkg::OP_TICK: begin
        if (is_provisioned) begin
          // Lease timeout first, then the retry deadline on the updated state.
          if (lease_fire) begin
            address_held_next   = 1'b0;
            link_phase_next     = lrb_pkg::PH_DHCP_FAIL;
            lease_mode_next     = lrb_pkg::LS_TIMEOUT;
            lease_deadline_next = '0;
            retry_counter_next  = arm_counter;
            backoff_value_next  = arm_delay;
            retry_deadline_next = arm_deadline;
            retry_status_next   = lrb_pkg::RM_BACKOFF;
          end
          if (retry_fire) begin
            link_phase_next     = lrb_pkg::PH_CONNECTING;
            lease_mode_next     = lrb_pkg::LS_UNKNOWN;
            retry_status_next   = lrb_pkg::RM_RETRYING;
            retry_deadline_next = '0;
          end
        end
      end
      default: begin
        // Unused codes leave the state alone.
      end
    endcase
  end

  // Action for one event: only a tick that fires a retry requests one.
  always_comb begin
    action_next = lrb_pkg::ACT_NONE;
    if (op == lrb_pkg::OP_TICK && is_provisioned && retry_fire) begin
      if (lease_fire || link_phase == lrb_pkg::PH_DHCP_FAIL) begin
        action_next = lrb_pkg::ACT_RECONNECT;
      end else begin
        action_next = lrb_pkg::ACT_CONNECT;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dhcp_timeout_ms <= 32'd10000;
    end else if (cfg_write) begin
      dhcp_timeout_ms <= cfg_wdata;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // State update on each accepted beat; the state also holds the result snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_provisioned  <= 1'b0;
      link_phase      <= lrb_pkg::PH_UNPROV;
      lease_mode      <= lrb_pkg::LS_UNKNOWN;
      retry_status    <= lrb_pkg::RM_DISABLED;
      address_held    <= 1'b0;
      ap_visibility   <= lrb_pkg::AP_UNKNOWN;
      last_rssi       <= lrb_pkg::RSSI_RESET;
      last_channel    <= '0;
      retry_counter   <= '0;
      backoff_value   <= '0;
      retry_deadline  <= '0;
      lease_deadline  <= '0;
      disconnect_code <= '0;
      success_set     <= 1'b0;
      success_wall_s  <= '0;
      action_q        <= lrb_pkg::ACT_NONE;
    end else if (accept) begin
      is_provisioned  <= is_provisioned_next;
      link_phase      <= link_phase_next;
      lease_mode      <= lease_mode_next;
      retry_status    <= retry_status_next;
      address_held    <= address_held_next;
      ap_visibility   <= ap_visibility_next;
      last_rssi       <= last_rssi_next;
      last_channel    <= last_channel_next;
      retry_counter   <= retry_counter_next;
      backoff_value   <= backoff_value_next;
      retry_deadline  <= retry_deadline_next;
      lease_deadline  <= lease_deadline_next;
      disconnect_code <= disconnect_code_next;
      success_set     <= success_set_next;
      success_wall_s  <= success_wall_s_next;
      action_q        <= action_next;
    end
  end

  // Result fields.
  assign action           = action_q;
  assign phase            = link_phase;
  assign lease_state      = lease_mode;
  assign retry_mode       = retry_status;
  assign has_address      = address_held;
  assign ap_seen          = ap_visibility;
  assign signal_dbm       = last_rssi;
  assign radio_channel    = last_channel;
  assign retries          = retry_counter;
  assign backoff_delay_ms = backoff_value;
  assign last_reason      = disconnect_code;
  assign success_utc_s    = success_wall_s;

endmodule

`default_nettype wire

// ===== sv/lrb_checker.sv =====
// Port-level checks for the link reconnect backoff supervisor, bound to its top level.
`default_nettype none

module lrb_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         action,
  input wire logic [3:0]         phase,
  input wire logic [1:0]         lease_state,
  input wire logic [1:0]         retry_mode,
  input wire logic [15:0]        retries,
  input wire logic [15:0]        backoff_delay_ms
);

  // A requested connect or reconnect always leaves the link connecting with a retry in flight.
  a_action_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action != lrb_pkg::ACT_NONE) |->
      (phase == lrb_pkg::PH_CONNECTING && retry_mode == lrb_pkg::RM_RETRYING &&
       lease_state == lrb_pkg::LS_UNKNOWN))
    else $error("action requested without retry state");

  // A nonzero backoff delay always comes with a nonzero retry count.
  a_delay_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && backoff_delay_ms != 16'd0) |-> (retries != 16'd0))
    else $error("backoff delay without retry count");

  // Every nonzero backoff delay is one of the table entries.
  a_delay_table: assert property (@(posedge clk) disable iff (rst)
    (out_valid && backoff_delay_ms != 16'd0) |->
      (backoff_delay_ms == 16'd2000 || backoff_delay_ms == 16'd4000 ||
       backoff_delay_ms == 16'd8000 || backoff_delay_ms == 16'd15000 ||
       backoff_delay_ms == 16'd30000 || backoff_delay_ms == 16'd60000))
    else $error("backoff delay outside table");

  // Each accepted event beat gives a result beat on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted event gave no result");

  // A stalled result beat holds its status.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(phase) && $stable(retries)))
    else $error("stalled result changed");

endmodule

bind link_reconnect_backoff_fsm_top lrb_checker u_lrb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .action           (action),
  .phase            (phase),
  .lease_state      (lease_state),
  .retry_mode       (retry_mode),
  .retries          (retries),
  .backoff_delay_ms (backoff_delay_ms)
);

`default_nettype wire

// ===== dv/link_supervisor_checker.sv =====
// Checker for the link supervisor: predicts each status beat and compares it with the block.
module link_supervisor_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [3:0]        operation,
  input  logic [47:0]       now_ms,
  input  logic              provisioned,
  input  logic signed [7:0] rssi,
  input  logic [7:0]        channel,
  input  logic [15:0]       reason,
  input  logic [31:0]       utc_seconds,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        action,
  input  logic [3:0]        phase,
  input  logic [1:0]        lease_state,
  input  logic [1:0]        retry_mode,
  input  logic              has_address,
  input  logic signed [1:0] ap_seen,
  input  logic signed [7:0] signal_dbm,
  input  logic [7:0]        radio_channel,
  input  logic [15:0]       retries,
  input  logic [15:0]       backoff_delay_ms,
  input  logic [15:0]       last_reason,
  input  logic [31:0]       success_utc_s,
  output int                mismatches,
  output int                awaiting,
  output int                statuses_checked,
  output int                connects_requested
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted status beat.
  typedef struct {
    lrb_pkg::action_t  act;
    lrb_pkg::phase_t   ph;
    lrb_pkg::lease_t   ls;
    lrb_pkg::retry_t   rm;
    logic              addr;
    logic signed [1:0] ap;
    logic signed [7:0] rssi;
    logic [7:0]        chan;
    logic [15:0]       streak;
    logic [15:0]       delay;
    logic [15:0]       rsn;
    logic [31:0]       utc;
  } link_status_t;

  link_status_t status_fifo[$];
  link_status_t want_status;
  link_status_t new_status;
  int           reported;

  // Shadow copy of the supervisor state and its register.
  logic              creds_ok;
  lrb_pkg::phase_t   cur_phase;
  lrb_pkg::lease_t   cur_lease;
  lrb_pkg::retry_t   cur_retry;
  logic              addr_up;
  logic signed [1:0] ap_state;
  logic signed [7:0] rssi_last;
  logic [7:0]        chan_last;
  logic [15:0]       fail_streak;
  logic [15:0]       cur_delay;
  logic [47:0]       retry_due;
  logic [47:0]       lease_due;
  logic [15:0]       reason_last;
  logic [47:0]       bound_at_ms;
  logic [31:0]       bound_utc;
  logic [31:0]       lease_timeout;

  // Deadline arithmetic clamps at the top of the time range.
  function automatic logic [47:0] clamp_add_ms(logic [47:0] base, logic [47:0] delay);
    logic [48:0] sum;
    sum = {1'b0, base} + {1'b0, delay};
    return sum[48] ? lrb_pkg::TIME_MAX : sum[47:0];
  endfunction

  // Delay grows with the failure streak and stops at the last step.
  function automatic logic [15:0] delay_for_streak(logic [15:0] streak);
    case (streak)
      16'd1:   return 16'd2000;
      16'd2:   return 16'd4000;
      16'd3:   return 16'd8000;
      16'd4:   return 16'd15000;
      16'd5:   return 16'd30000;
      default: return 16'd60000;
    endcase
  endfunction

  // Groups of disconnect reasons.
  function automatic lrb_pkg::reason_class_t group_of_reason(logic [15:0] r);
    case (r)
      16'd2, 16'd6, 16'd7, 16'd15, 16'd23, 16'd24, 16'd202, 16'd204: return lrb_pkg::RC_AUTH;
      16'd200, 16'd201, 16'd210, 16'd211, 16'd212: return lrb_pkg::RC_NO_AP;
      16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14,
      16'd16, 16'd17, 16'd18, 16'd203: return lrb_pkg::RC_ASSOC;
      default: return lrb_pkg::RC_OTHER;
    endcase
  endfunction

  // A failure extends the streak and arms the next retry.
  task automatic arm_retry(logic [47:0] t);
    if (fail_streak != lrb_pkg::COUNT_MAX) begin
      fail_streak = fail_streak + 16'd1;
    end
    cur_delay = delay_for_streak(fail_streak);
    retry_due = clamp_add_ms(t, {32'd0, cur_delay});
    cur_retry = lrb_pkg::RM_BACKOFF;
  endtask

  // Apply one event to the shadow state and return the status it produces.
  task automatic predict_status(input logic [3:0] op, input logic [47:0] t, input logic prov,
                                input logic signed [7:0] rs, input logic [7:0] ch,
                                input logic [15:0] rsn, input logic [31:0] utc,
                                output link_status_t st);
    lrb_pkg::action_t act;
    act = lrb_pkg::ACT_NONE;
    if (op == lrb_pkg::OP_PROVISION) begin
      creds_ok    = prov;
      addr_up     = 1'b0;
      cur_lease   = lrb_pkg::LS_UNKNOWN;
      lease_due   = '0;
      fail_streak = '0;
      cur_delay   = '0;
      reason_last = '0;
      ap_state    = lrb_pkg::AP_UNKNOWN;
      rssi_last   = lrb_pkg::RSSI_RESET;
      chan_last   = '0;
      bound_at_ms = '0;
      bound_utc   = '0;
      if (prov) begin
        cur_phase = lrb_pkg::PH_DISCONN;
        cur_retry = lrb_pkg::RM_BACKOFF;
        retry_due = t;
      end else begin
        cur_phase = lrb_pkg::PH_UNPROV;
        cur_retry = lrb_pkg::RM_DISABLED;
        retry_due = '0;
      end
    end else if (op == lrb_pkg::OP_SET_UTC) begin
      // Wall time is only recorded once a success time exists.
      if (utc != 32'd0 && bound_at_ms != 48'd0) begin
        bound_utc = utc;
      end
    end else if (op < lrb_pkg::OP_SET_UTC && creds_ok) begin
      case (op)
        lrb_pkg::OP_DRV_START: begin
          cur_phase = lrb_pkg::PH_DISCONN;
          cur_retry = lrb_pkg::RM_BACKOFF;
          cur_delay = '0;
          retry_due = t;
        end
        lrb_pkg::OP_ASSOC: begin
          cur_phase = lrb_pkg::PH_DHCP;
          cur_lease = lrb_pkg::LS_REQUESTING;
          cur_retry = lrb_pkg::RM_IDLE;
          cur_delay = '0;
          retry_due = '0;
          lease_due = clamp_add_ms(t, {16'd0, lease_timeout});
          ap_state  = lrb_pkg::AP_YES;
        end
        lrb_pkg::OP_GOT_IP: begin
          cur_phase   = lrb_pkg::PH_CONNECTED;
          cur_lease   = lrb_pkg::LS_BOUND;
          cur_retry   = lrb_pkg::RM_IDLE;
          addr_up     = 1'b1;
          ap_state    = lrb_pkg::AP_YES;
          rssi_last   = rs;
          chan_last   = ch;
          fail_streak = '0;
          cur_delay   = '0;
          retry_due   = '0;
          lease_due   = '0;
          bound_at_ms = t;
        end
        lrb_pkg::OP_LOST_IP: begin
          addr_up   = 1'b0;
          cur_phase = lrb_pkg::PH_DHCP_FAIL;
          cur_lease = lrb_pkg::LS_TIMEOUT;
          lease_due = '0;
          arm_retry(t);
        end
        lrb_pkg::OP_DISCONN: begin
          addr_up     = 1'b0;
          cur_lease   = lrb_pkg::LS_UNKNOWN;
          lease_due   = '0;
          reason_last = rsn;
          case (group_of_reason(rsn))
            lrb_pkg::RC_AUTH: begin
              cur_phase = lrb_pkg::PH_AUTH_FAIL;
              ap_state  = lrb_pkg::AP_YES;
            end
            lrb_pkg::RC_NO_AP: begin
              cur_phase = lrb_pkg::PH_AP_UNAVAIL;
              ap_state  = lrb_pkg::AP_NO;
            end
            lrb_pkg::RC_ASSOC: begin
              cur_phase = lrb_pkg::PH_ASSOC_FAIL;
              ap_state  = lrb_pkg::AP_YES;
            end
            default: begin
              cur_phase = lrb_pkg::PH_DISCONN;
              ap_state  = lrb_pkg::AP_UNKNOWN;
            end
          endcase
          arm_retry(t);
        end
        lrb_pkg::OP_CONN_FAIL: begin
          addr_up   = 1'b0;
          cur_phase = lrb_pkg::PH_FAILED;
          cur_lease = lrb_pkg::LS_UNKNOWN;
          ap_state  = lrb_pkg::AP_UNKNOWN;
          arm_retry(t);
        end
        default: begin
          // Tick: lease timeout first, then the retry deadline on the updated state.
          if (cur_phase == lrb_pkg::PH_DHCP && lease_due != 48'd0 && t >= lease_due) begin
            addr_up   = 1'b0;
            cur_phase = lrb_pkg::PH_DHCP_FAIL;
            cur_lease = lrb_pkg::LS_TIMEOUT;
            lease_due = '0;
            arm_retry(t);
          end
          if (cur_retry == lrb_pkg::RM_BACKOFF && t >= retry_due) begin
            act       = (cur_phase == lrb_pkg::PH_DHCP_FAIL) ? lrb_pkg::ACT_RECONNECT
                                                              : lrb_pkg::ACT_CONNECT;
            cur_phase = lrb_pkg::PH_CONNECTING;
            cur_lease = lrb_pkg::LS_UNKNOWN;
            cur_retry = lrb_pkg::RM_RETRYING;
            retry_due = '0;
          end
        end
      endcase
    end
    st.act    = act;
    st.ph     = cur_phase;
    st.ls     = cur_lease;
    st.rm     = cur_retry;
    st.addr   = addr_up;
    st.ap     = ap_state;
    st.rssi   = rssi_last;
    st.chan   = chan_last;
    st.streak = fail_streak;
    st.delay  = cur_delay;
    st.rsn    = reason_last;
    st.utc    = bound_utc;
  endtask

  // Compare one field of a status beat and report a difference.
  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (reported < 40) begin
        reported++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v,
                 got_v);
      end
    end
  endtask

  // Watch both channels at each rising edge; the status beat leaving is always older.
  always @(posedge clk) begin
    if (rst) begin
      creds_ok      = 1'b0;
      cur_phase     = lrb_pkg::PH_UNPROV;
      cur_lease     = lrb_pkg::LS_UNKNOWN;
      cur_retry     = lrb_pkg::RM_DISABLED;
      addr_up       = 1'b0;
      ap_state      = lrb_pkg::AP_UNKNOWN;
      rssi_last     = lrb_pkg::RSSI_RESET;
      chan_last     = '0;
      fail_streak   = '0;
      cur_delay     = '0;
      retry_due     = '0;
      lease_due     = '0;
      reason_last   = '0;
      bound_at_ms   = '0;
      bound_utc     = '0;
      lease_timeout = 32'd10000;
      status_fifo.delete();
      awaiting      = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_fifo.size() == 0) begin
          mismatches++;
          $display("%0t ns: status beat with no event waiting, expected none, actual phase 0x%0h",
                   $time, phase);
        end else begin
          want_status = status_fifo.pop_front();
          statuses_checked++;
          check_field("action", 64'(want_status.act), 64'(action));
          check_field("phase", 64'(want_status.ph), 64'(phase));
          check_field("lease_state", 64'(want_status.ls), 64'(lease_state));
          check_field("retry_mode", 64'(want_status.rm), 64'(retry_mode));
          check_field("has_address", 64'(want_status.addr), 64'(has_address));
          check_field("ap_seen", 64'(want_status.ap), 64'(ap_seen));
          check_field("signal_dbm", 64'(want_status.rssi), 64'(signal_dbm));
          check_field("radio_channel", 64'(want_status.chan), 64'(radio_channel));
          check_field("retries", 64'(want_status.streak), 64'(retries));
          check_field("backoff_delay_ms", 64'(want_status.delay), 64'(backoff_delay_ms));
          check_field("last_reason", 64'(want_status.rsn), 64'(last_reason));
          check_field("success_utc_s", 64'(want_status.utc), 64'(success_utc_s));
        end
      end
      if (cfg_write) begin
        lease_timeout = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_status(operation, now_ms, provisioned, rssi, channel, reason, utc_seconds,
                       new_status);
        status_fifo.push_back(new_status);
        if (new_status.act != lrb_pkg::ACT_NONE) begin
          connects_requested++;
        end
      end
      awaiting = status_fifo.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the link supervisor testbench: clock, reset, event stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [31:0]       cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [3:0]        operation;
  logic [47:0]       now_ms;
  logic              provisioned;
  logic signed [7:0] rssi;
  logic [7:0]        channel;
  logic [15:0]       reason;
  logic [31:0]       utc_seconds;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        action;
  logic [3:0]        phase;
  logic [1:0]        lease_state;
  logic [1:0]        retry_mode;
  logic              has_address;
  logic signed [1:0] ap_seen;
  logic signed [7:0] signal_dbm;
  logic [7:0]        radio_channel;
  logic [15:0]       retries;
  logic [15:0]       backoff_delay_ms;
  logic [15:0]       last_reason;
  logic [31:0]       success_utc_s;

  int mismatches;
  int awaiting;
  int statuses_checked;
  int connects_requested;

  // Stimulus bookkeeping.
  int          in_idle_pct;
  int          out_idle_pct;
  int          events_sent;
  int          timeout_settings;
  logic        link_enabled;
  logic [47:0] clock_ms;

  // Reason codes that fall into the auth, no-AP and association groups.
  localparam logic [26*16-1:0] GROUPED_REASONS = {
    16'd2, 16'd6, 16'd7, 16'd15, 16'd23, 16'd24, 16'd202, 16'd204,
    16'd200, 16'd201, 16'd210, 16'd211, 16'd212,
    16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14,
    16'd16, 16'd17, 16'd18, 16'd203
  };

  always #6 clk = ~clk;

  link_reconnect_backoff_fsm_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .now_ms           (now_ms),
    .provisioned      (provisioned),
    .rssi             (rssi),
    .channel          (channel),
    .reason           (reason),
    .utc_seconds      (utc_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .phase            (phase),
    .lease_state      (lease_state),
    .retry_mode       (retry_mode),
    .has_address      (has_address),
    .ap_seen          (ap_seen),
    .signal_dbm       (signal_dbm),
    .radio_channel    (radio_channel),
    .retries          (retries),
    .backoff_delay_ms (backoff_delay_ms),
    .last_reason      (last_reason),
    .success_utc_s    (success_utc_s)
  );

  link_supervisor_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .now_ms             (now_ms),
    .provisioned        (provisioned),
    .rssi               (rssi),
    .channel            (channel),
    .reason             (reason),
    .utc_seconds        (utc_seconds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action             (action),
    .phase              (phase),
    .lease_state        (lease_state),
    .retry_mode         (retry_mode),
    .has_address        (has_address),
    .ap_seen            (ap_seen),
    .signal_dbm         (signal_dbm),
    .radio_channel      (radio_channel),
    .retries            (retries),
    .backoff_delay_ms   (backoff_delay_ms),
    .last_reason        (last_reason),
    .success_utc_s      (success_utc_s),
    .mismatches         (mismatches),
    .awaiting           (awaiting),
    .statuses_checked   (statuses_checked),
    .connects_requested (connects_requested)
  );

  // Send one event beat, with random idle cycles ahead of it.
  task automatic post_event(input logic [3:0] op, input logic [47:0] at, input logic prov,
                            input logic [7:0] rs, input logic [7:0] ch, input logic [15:0] rsn,
                            input logic [31:0] utc);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    now_ms      <= at;
    provisioned <= prov;
    rssi        <= rs;
    channel     <= ch;
    reason      <= rsn;
    utc_seconds <= utc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    events_sent++;
    if (op == lrb_pkg::OP_PROVISION) begin
      link_enabled = prov;
    end
  endtask

  // Hold off the sender until every status beat has been drained.
  task automatic drain_statuses();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write the lease timeout while the block is idle.
  task automatic write_lease_timeout(input logic [31:0] value);
    drain_statuses();
    cfg_write <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    timeout_settings++;
  endtask

  // Advance the event clock: mostly small steps, sometimes far jumps or backward.
  function automatic logic [47:0] next_stamp(logic [47:0] t);
    int r;
    r = $urandom_range(99);
    if (r < 70) return t + 48'($urandom_range(3000));
    if (r < 90) return t + 48'($urandom_range(70000));
    if (r < 95) return {16'($urandom), 32'($urandom)};
    if (r < 98) return lrb_pkg::TIME_MAX - 48'($urandom_range(100000));
    return t - 48'($urandom_range(5000));
  endfunction

  function automatic logic [15:0] pick_reason();
    int r;
    r = $urandom_range(9);
    if (r < 3) return GROUPED_REASONS[$urandom_range(25)*16 +: 16];
    if (r < 6) return 16'($urandom_range(255));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_utc();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Random sessions: mostly well-formed link traffic, with some noise and resets.
  task automatic run_sessions(input int target);
    int          done;
    int          r;
    logic [3:0]  op;
    logic        prov;
    logic        counts;
    done = 0;
    while (done < target) begin
      clock_ms = next_stamp(clock_ms);
      r = $urandom_range(999);
      prov = ($urandom_range(19) != 0);
      if (!link_enabled) begin
        op = (r < 700) ? lrb_pkg::OP_PROVISION : 4'($urandom_range(15));
        prov = ($urandom_range(9) != 0);
      end else if (r < 400) op = lrb_pkg::OP_TICK;
      else if (r < 550) op = lrb_pkg::OP_ASSOC;
      else if (r < 650) op = lrb_pkg::OP_GOT_IP;
      else if (r < 700) op = lrb_pkg::OP_LOST_IP;
      else if (r < 800) op = lrb_pkg::OP_DISCONN;
      else if (r < 870) op = lrb_pkg::OP_CONN_FAIL;
      else if (r < 930) op = lrb_pkg::OP_SET_UTC;
      else if (r < 960) op = lrb_pkg::OP_DRV_START;
      else if (r < 985) op = lrb_pkg::OP_PROVISION;
      else op = 4'($urandom_range(9, 15));
      counts = (op == lrb_pkg::OP_PROVISION) || (op == lrb_pkg::OP_SET_UTC) ||
               (op < lrb_pkg::OP_SET_UTC && link_enabled);
      post_event(op, clock_ms, prov, 8'($urandom), 8'($urandom), pick_reason(), pick_utc());
      if (counts) done++;
    end
  endtask

  // Result side: stall at random according to the current idle share.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [31:0] lease_timeouts [6];
    int          seg;
    int          k;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    operation    = '0;
    now_ms       = '0;
    provisioned  = 1'b0;
    rssi         = '0;
    channel      = '0;
    reason       = '0;
    utc_seconds  = '0;
    in_idle_pct  = 32;
    out_idle_pct = 55;
    events_sent  = 0;
    timeout_settings = 0;
    link_enabled = 1'b0;
    clock_ms     = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ignored events, provisioning, saturated deadlines, reason groups, wall time.
    post_event(lrb_pkg::OP_TICK, 48'd0, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(4'd9, 48'd7, 1'b1, 8'h11, 8'h22, 16'd33, 32'd44);
    post_event(4'd15, lrb_pkg::TIME_MAX, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    post_event(lrb_pkg::OP_SET_UTC, 48'd10, 1'b0, 8'h00, 8'h00, 16'd0, 32'd1234);
    post_event(lrb_pkg::OP_PROVISION, lrb_pkg::TIME_MAX, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_PROVISION, 48'd0, 1'b1, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_TICK, 48'd0, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_GOT_IP, 48'd0, 1'b0, 8'h80, 8'hFF, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_SET_UTC, 48'd0, 1'b0, 8'h00, 8'h00, 16'd0, 32'hFFFF_FFFF);
    post_event(lrb_pkg::OP_DRV_START, 48'd100, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_CONN_FAIL, lrb_pkg::TIME_MAX - 48'd1000, 1'b0, 8'h00, 8'h00,
               16'd0, 32'd0);
    post_event(lrb_pkg::OP_TICK, lrb_pkg::TIME_MAX, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_ASSOC, lrb_pkg::TIME_MAX - 48'd5, 1'b0, 8'h00, 8'h00, 16'd0,
               32'd0);
    post_event(lrb_pkg::OP_TICK, lrb_pkg::TIME_MAX, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_DISCONN, 48'd1000, 1'b0, 8'h00, 8'h00, 16'd202, 32'd0);
    post_event(lrb_pkg::OP_DISCONN, 48'd1001, 1'b0, 8'h00, 8'h00, 16'd200, 32'd0);
    post_event(lrb_pkg::OP_DISCONN, 48'd1002, 1'b0, 8'h00, 8'h00, 16'd203, 32'd0);
    post_event(lrb_pkg::OP_DISCONN, 48'd1003, 1'b0, 8'h00, 8'h00, 16'hFFFF, 32'd0);
    post_event(lrb_pkg::OP_LOST_IP, 48'd1004, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_GOT_IP, 48'd5000, 1'b0, 8'h7F, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_SET_UTC, 48'd5001, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_SET_UTC, 48'd5002, 1'b0, 8'h00, 8'h00, 16'd0, 32'hFFFF_FFFF);

    // A zero timeout with association at time zero leaves no lease deadline armed.
    write_lease_timeout(32'd0);
    post_event(lrb_pkg::OP_ASSOC, 48'd0, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_TICK, 48'd0, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_TICK, 48'd1, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0);

    // Random sessions across several timeout settings and idle patterns.
    lease_timeouts[0] = 32'd3000;
    lease_timeouts[1] = 32'd0;
    lease_timeouts[2] = 32'hFFFF_FFFF;
    lease_timeouts[3] = $urandom_range(1, 20000);
    lease_timeouts[4] = $urandom;
    lease_timeouts[5] = 32'd10000;
    for (seg = 0; seg < 6; seg++) begin
      write_lease_timeout(lease_timeouts[seg]);
      in_idle_pct  = (seg < 2) ? 32 : (seg < 4) ? 55 : 0;
      out_idle_pct = (seg < 2) ? 55 : (seg < 4) ? 32 : 0;
      run_sessions(240);
    end

    // A long run of failures walks the delay table to its last step.
    write_lease_timeout(32'd3000);
    post_event(lrb_pkg::OP_PROVISION, clock_ms, 1'b1, 8'h00, 8'h00, 16'd0, 32'd0);
    for (k = 0; k < 40; k++) begin
      clock_ms = clock_ms + 48'($urandom_range(200));
      post_event(($urandom_range(9) == 0) ? lrb_pkg::OP_TICK : lrb_pkg::OP_CONN_FAIL,
                 clock_ms, 1'b1, 8'($urandom), 8'($urandom), pick_reason(), pick_utc());
    end
    post_event(lrb_pkg::OP_DISCONN, clock_ms, 1'b1, 8'h00, 8'h00, 16'd211, 32'd0);
    post_event(lrb_pkg::OP_TICK, lrb_pkg::TIME_MAX, 1'b1, 8'h00, 8'h00, 16'd0, 32'd0);
    post_event(lrb_pkg::OP_GOT_IP, lrb_pkg::TIME_MAX, 1'b1, 8'hC4, 8'd11, 16'd0, 32'd0);

    drain_statuses();
    repeat (4) @(negedge clk);
    $display("Run covered %0d events and %0d status beats, %0d of them connect requests,",
             events_sent, statuses_checked, connects_requested);
    $display("over %0d lease timeout settings and a long run of repeated connect failures.",
             timeout_settings);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
